// ===== hdl/qrs_pkg.sv =====
// Package: shared constants and types for the quadratic root solver.
package qrs_pkg;

  localparam int CoefWidthDef = 16;
  localparam int FracBitsDef  = 16;
  localparam int RootWidth    = 40;

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_AZERO  = 2'd3
  } status_t;

endpackage

// ===== hdl/quadratic_root_solver.sv =====
// Top level: pipelined real-root solver for a*x^2 + b*x + c in signed fixed point.
//
//  channel | direction | tdata fields (low bit first)          | tuser
//  in_     | input     | coef_a, coef_b, coef_c                 | -
//  out_    | output    | status, root_plus, root_minus          | -
//
// One item is accepted per cycle while the output is not stalled. The pipe holds the
// product and discriminant stages, SQN (COEF_WIDTH+FRAC_BITS+2) root stages, SW+1 divider
// stages and the output register; the square root and divider chains are bit-serial, one bit per stage.
// rst_n clears only the stage valid bits; payload registers are not reset.
// A stall on out_tready freezes the whole pipe; in_tready follows it and stays low
// during reset, so nothing is lost.
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::CoefWidthDef,
  parameter int FRAC_BITS  = qrs_pkg::FracBitsDef
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      in_tdata,  // coef_a, coef_b, coef_c
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2+2*qrs_pkg::RootWidth+7)/8)*8-1:0] out_tdata // status, root_plus, root_minus
);
  import qrs_pkg::*;

  localparam int CW   = COEF_WIDTH;
  localparam int DW   = 2*CW + 3;               // |D| < 5*2^(2CW-2), unsigned
  localparam int SDW  = DW + 2*FRAC_BITS;       // scaled discriminant width
  localparam int SQN  = (SDW+1)/2;              // root result bits / stages
  localparam int SDE  = 2*SQN;
  localparam int NW   = CW + FRAC_BITS + 2;     // -b*2^F +- S fits
  localparam int SW   = (NW > SQN + 2 ? NW : SQN + 2);
  localparam int DENW = CW + 1;
  localparam int LAT  = 2 + SQN + (SW + 1) + 1;
  localparam int OTW  = ((2+2*RootWidth+7)/8)*8;
  localparam int XW   = (SW > RootWidth ? SW : RootWidth) + 1;

  logic adv;
  assign adv       = out_tready || !out_tvalid;
  assign in_tready = adv && rst_n;

  // Valid bits travel down the pipe.
  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[LAT-1];

  // Stage 1: products.
  logic signed [CW-1:0] a_in, b_in, c_in;
  assign a_in = in_tdata[CW-1:0];
  assign b_in = in_tdata[2*CW-1:CW];
  assign c_in = in_tdata[3*CW-1:2*CW];

  logic signed [2*CW:0] bb_r, ac_r;
  logic signed [CW-1:0] a1_r, b1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      bb_r <= (2*CW+1)'(b_in * b_in);
      ac_r <= (2*CW+1)'(a_in * c_in);
      a1_r <= a_in;
      b1_r <= b_in;
    end
  end

  // Stage 2: discriminant and status.
  logic signed [DW:0] disc;
  assign disc = (DW+1)'(bb_r) - ((DW+1)'(ac_r) <<< 2);

  logic [DW-1:0]        d2_r;
  status_t              st2_r;
  logic signed [CW-1:0] a2_r, b2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      d2_r <= disc[DW-1:0];
      a2_r <= a1_r;
      b2_r <= b1_r;
      if (a1_r == '0)      st2_r <= ST_AZERO;
      else if (disc[DW])   st2_r <= ST_NONE;
      else if (disc == '0) st2_r <= ST_DOUBLE;
      else                 st2_r <= ST_TWO;
    end
  end

  // Square-root pipeline, one result bit per stage.
  logic [SDE-1:0]       sx_r  [SQN+1];
  logic [SQN+1:0]       sr_r  [SQN+1];
  logic [SQN-1:0]       sq_r  [SQN+1];
  status_t              sst_r [SQN+1];
  logic signed [CW-1:0] sa_r  [SQN+1];
  logic signed [CW-1:0] sb_r  [SQN+1];

  always_comb begin
    sx_r[0]  = SDE'(d2_r) << (2*FRAC_BITS);
    sr_r[0]  = '0;
    sq_r[0]  = '0;
    sst_r[0] = st2_r;
    sa_r[0]  = a2_r;
    sb_r[0]  = b2_r;
  end

  for (genvar g = 0; g < SQN; g++) begin : g_sqrt
    logic [SQN+1:0] rs, tt;
    assign rs = {sr_r[g][SQN-1:0], sx_r[g][SDE-1:SDE-2]};
    assign tt = {sq_r[g], 2'b01};
    always_ff @(posedge clk) begin
      if (adv) begin
        sx_r[g+1]  <= sx_r[g] << 2;
        if (rs >= tt) begin
          sr_r[g+1] <= rs - tt;
          sq_r[g+1] <= {sq_r[g][SQN-2:0], 1'b1};
        end else begin
          sr_r[g+1] <= rs;
          sq_r[g+1] <= {sq_r[g][SQN-2:0], 1'b0};
        end
        sst_r[g+1] <= sst_r[g];
        sa_r[g+1]  <= sa_r[g];
        sb_r[g+1]  <= sb_r[g];
      end
    end
  end

  // Numerators and denominator feeding two dividers.
  logic signed [SW-1:0]   nb, sv, nump, numm;
  logic signed [DENW-1:0] den;
  assign nb   = -(SW'(sb_r[SQN]) <<< FRAC_BITS);
  assign sv   = SW'({1'b0, sq_r[SQN]});
  assign nump = nb + sv;
  assign numm = nb - sv;
  assign den  = (sa_r[SQN][CW-1] == 1'b0 && sa_r[SQN] == '0) ? DENW'(1)
              : DENW'(sa_r[SQN]) <<< 1;

  logic signed [SW-1:0] qp, qm;
  qrs_divider #(.NUM_WIDTH(SW), .DEN_WIDTH(DENW)) u_divp (
    .clk(clk), .adv(adv), .num(nump), .den(den), .quo(qp));
  qrs_divider #(.NUM_WIDTH(SW), .DEN_WIDTH(DENW)) u_divm (
    .clk(clk), .adv(adv), .num(numm), .den(den), .quo(qm));

  // Status delay alongside the dividers: a load stage plus one stage per quotient bit.
  status_t dst_r [SW+2];
  always_comb dst_r[0] = sst_r[SQN];
  for (genvar g = 0; g < SW + 2; g++) begin : g_sdly
    if (g > 0) begin : g_d
      always_ff @(posedge clk) if (adv) dst_r[g] <= dst_r[g-1];
    end
  end

  // Saturate to the root width.
  function automatic logic [RootWidth-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [XW-1:0] hi, lo, vx;
    hi = XW'({1'b0, {(RootWidth-1){1'b1}}});
    lo = -hi - 1;
    vx = XW'(v);
    if (vx > hi)      sat = {1'b0, {(RootWidth-1){1'b1}}};
    else if (vx < lo) sat = {1'b1, {(RootWidth-1){1'b0}}};
    else              sat = vx[RootWidth-1:0];
  endfunction

  // Output register.
  status_t              ost_r;
  logic [RootWidth-1:0] orp_r, orm_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ost_r <= dst_r[SW+1];
      if (dst_r[SW+1] == ST_NONE || dst_r[SW+1] == ST_AZERO) begin
        orp_r <= '0;
        orm_r <= '0;
      end else begin
        orp_r <= sat(qp);
        orm_r <= sat(qm);
      end
    end
  end

  assign out_tdata = OTW'({orm_r, orp_r, ost_r});

  // A stalled result must hold until it is taken.
  property p_hold;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata));
  endproperty
  assert property (p_hold) else $error("stalled result changed");

  // Zero status codes carry zero roots.
  property p_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && (ost_r == ST_NONE || ost_r == ST_AZERO)) |-> (orp_r == '0 && orm_r == '0);
  endproperty
  assert property (p_zero) else $error("nonzero root with no-root status");

  // A double root has equal fields.
  property p_dbl;
    @(posedge clk) disable iff (!rst_n)
      (out_tvalid && ost_r == ST_DOUBLE) |-> (orp_r == orm_r);
  endproperty
  assert property (p_dbl) else $error("double root fields differ");

endmodule

// ===== hdl/qrs_divider.sv =====
// Pipelined restoring divider: signed quotient truncated toward zero, one bit per stage.
module qrs_divider #(
  parameter int NUM_WIDTH = 48,
  parameter int DEN_WIDTH = 34
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [NUM_WIDTH-1:0] num,
  input  logic signed [DEN_WIDTH-1:0] den,
  output logic signed [NUM_WIDTH-1:0] quo
);

  localparam int NS = NUM_WIDTH;

  // Per-stage remainder, quotient-in-progress, divisor magnitude and sign.
  logic [DEN_WIDTH:0]   rem_r   [NS+1];
  logic [NUM_WIDTH-1:0] nq_r    [NS+1];
  logic [DEN_WIDTH-1:0] dm_r    [NS+1];
  logic                 neg_r   [NS+1];

  // Stage 0 loads the magnitudes.
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
      dm_r[0]  <= den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
      neg_r[0] <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
    end
  end

  // One quotient bit per stage: shift in the next numerator bit, try subtract.
  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [DEN_WIDTH+1:0] shifted;
    logic [DEN_WIDTH+1:0] diff;
    assign shifted = {rem_r[g], nq_r[g][NUM_WIDTH-1]};
    assign diff    = shifted - {2'b00, dm_r[g]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!diff[DEN_WIDTH+1]) begin
          rem_r[g+1] <= diff[DEN_WIDTH:0];
          nq_r[g+1]  <= {nq_r[g][NUM_WIDTH-2:0], 1'b1};
        end else begin
          rem_r[g+1] <= shifted[DEN_WIDTH:0];
          nq_r[g+1]  <= {nq_r[g][NUM_WIDTH-2:0], 1'b0};
        end
        dm_r[g+1]  <= dm_r[g];
        neg_r[g+1] <= neg_r[g];
      end
    end
  end

  assign quo = neg_r[NS] ? NUM_WIDTH'(-nq_r[NS]) : NUM_WIDTH'(nq_r[NS]);

endmodule
